// ===== rtl/bvml_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvml_pkg
// Shared types and constants of the balance and velocity motor loop.
// ----------------------------------------------------------------------------
package bvml_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgMechOffset  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTargetTilt  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTargetLeft  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTargetRight = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDriveLimit  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDeadZone    = 3'd5;

  // register reset values
  localparam logic [13:0] DriveLimitRst = 14'd9500;
  localparam logic [9:0]  DeadZoneRst   = 10'd500;

  // arithmetic constants
  localparam int unsigned DrvDiv   = 160;      // balance term divisor
  localparam int unsigned FiltDiv  = 5;        // low-pass divisor
  localparam int unsigned IntegLim = 5120000;  // 20000 in Q.8
  localparam int unsigned DutyMax  = 16383;
  localparam int unsigned DivBits  = 27;       // bits through the serial dividers

  // input request
  typedef struct packed {
    logic signed [15:0] tilt_angle;
    logic signed [15:0] gyro_rate;
    logic [7:0]         count_left;
    logic [7:0]         count_right;
  } in_item_t;

  // result
  typedef struct packed {
    logic signed [14:0] balance_drive;
    logic [13:0]        duty;
    logic               forward;
    logic signed [15:0] velocity_drive;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/balance_velocity_motor_loop_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// balance_velocity_motor_loop_top
// PD balance drive with clamp, dead zone and direction, plus a velocity PI
// term on the summed encoder speed error that is reported alongside.
// ----------------------------------------------------------------------------
// One request is worked at a time; the next is taken only once the block is
// idle again. The result sits in an output register, so a stall there holds
// the block only once the following request is finished. The work runs
// through set-up (bias, multiply, magnitude), the two bit-serial constant
// dividers (balance term by 160, low-pass by 5), which shift one bit a cycle
// over 27 bits, then post-processing (filter, integral, velocity multiply and
// sum) and the final load; the next request is taken in the idle state.
// Configuration is written through a plain write port; the user must write
// it only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module balance_velocity_motor_loop_top
  import bvml_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  // request channel
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire in_item_t      in_data_i,
  // result channel
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output out_item_t          out_data_o,
  // configuration
  input  wire                cfg_we_i,
  input  wire [CfgIdxW-1:0]  cfg_idx_i,
  input  wire [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(DivBits);

  typedef enum logic [3:0] {
    S_IDLE, S_BIAS, S_MUL, S_ABS, S_DIV, S_POST, S_INT, S_VMUL, S_VSUM, S_FIN
  } state_e;

  state_e state_q;
  logic [CntW-1:0] cnt_q;
  logic out_valid_q;

  // configuration registers
  logic signed [15:0] cfg_offset_q, cfg_tilt_q;
  logic [7:0]  cfg_tl_q, cfg_tr_q;
  logic [13:0] cfg_limit_q;
  logic [9:0]  cfg_dead_q;

  // loop state
  logic signed [19:0] filt_q;
  logic signed [23:0] integ_q;

  // datapath
  in_item_t           in_q;
  logic signed [17:0] bias_q;
  logic signed [10:0] err_q;
  logic signed [26:0] pa_q;
  logic signed [22:0] pb_q;
  logic signed [22:0] fnum_q;
  logic               drv_neg_q, filt_neg_q;
  logic [DivBits-1:0] drv_sh_q, filt_sh_q;
  logic [7:0]         drv_rem_q;
  logic [2:0]         filt_rem_q;
  logic signed [27:0] vprod_q;
  logic signed [28:0] vnum_q;
  out_item_t          out_q;

  logic in_acc, out_load;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // serial divider steps, one quotient bit each
  logic [8:0] drv_trial;
  logic [3:0] filt_trial;
  logic       drv_ge, filt_ge;
  logic [7:0] drv_rem_d;
  logic [2:0] filt_rem_d;

  always_comb begin
    drv_trial  = {drv_rem_q, drv_sh_q[DivBits-1]};
    drv_ge     = drv_trial >= 9'(DrvDiv);
    drv_rem_d  = drv_ge ? 8'(drv_trial - 9'(DrvDiv)) : drv_trial[7:0];
    filt_trial = {filt_rem_q, filt_sh_q[DivBits-1]};
    filt_ge    = filt_trial >= 4'(FiltDiv);
    filt_rem_d = filt_ge ? 3'(filt_trial - 4'(FiltDiv)) : filt_trial[2:0];
  end

  // signed numerators and their magnitudes
  logic signed [26:0] num;
  logic signed [22:0] fnum_d;
  logic [26:0] num_mag;
  logic [22:0] fnum_mag;

  always_comb begin
    num      = pa_q + 27'(pb_q);
    num_mag  = num[26] ? 27'(-num) : 27'(num);
    fnum_mag = fnum_q[22] ? 23'(-fnum_q) : 23'(fnum_q);
    fnum_d   = $signed({filt_q[19], filt_q, 2'b00})
             + $signed({{4{err_q[10]}}, err_q, 8'b0});
  end

  // drive clamp, duty, direction and new filter value
  logic signed [18:0] drive_raw, drive_c, lim_s;
  logic [14:0] drive_mag, duty_sum;
  logic signed [19:0] filt_new;
  logic [17:0] drv_quo;
  logic [19:0] filt_quo;

  always_comb begin
    drv_quo   = drv_sh_q[17:0];
    drive_raw = drv_neg_q ? -$signed({1'b0, drv_quo}) : $signed({1'b0, drv_quo});
    lim_s     = $signed({5'b0, cfg_limit_q});
    if (drive_raw > lim_s) begin
      drive_c = lim_s;
    end else if (drive_raw < -lim_s) begin
      drive_c = -lim_s;
    end else begin
      drive_c = drive_raw;
    end
    drive_mag = drive_c[18] ? 15'(-drive_c) : 15'(drive_c);
    duty_sum  = drive_mag + 15'(cfg_dead_q);
    filt_quo  = filt_sh_q[19:0];
    filt_new  = filt_neg_q ? -$signed(filt_quo) : $signed(filt_quo);
  end

  // integral with clamp
  logic signed [24:0] isum, integ_d;

  always_comb begin
    isum = 25'(integ_q) + 25'(filt_q);
    if (isum > $signed(25'(IntegLim))) begin
      integ_d = $signed(25'(IntegLim));
    end else if (isum < -$signed(25'(IntegLim))) begin
      integ_d = -$signed(25'(IntegLim));
    end else begin
      integ_d = isum;
    end
  end

  // velocity term, truncated toward zero over 1024
  logic [28:0] vmag;
  logic [15:0] vquo;
  logic signed [15:0] vel;

  always_comb begin
    vmag = vnum_q[28] ? 29'(-vnum_q) : 29'(vnum_q);
    vquo = vmag[25:10];
    vel  = vnum_q[28] ? -$signed(vquo) : $signed(vquo);
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_offset_q <= '0;
      cfg_tilt_q   <= '0;
      cfg_tl_q     <= '0;
      cfg_tr_q     <= '0;
      cfg_limit_q  <= DriveLimitRst;
      cfg_dead_q   <= DeadZoneRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMechOffset:  cfg_offset_q <= $signed(cfg_data_i);
        CfgTargetTilt:  cfg_tilt_q   <= $signed(cfg_data_i);
        CfgTargetLeft:  cfg_tl_q     <= cfg_data_i[7:0];
        CfgTargetRight: cfg_tr_q     <= cfg_data_i[7:0];
        CfgDriveLimit:  cfg_limit_q  <= cfg_data_i[13:0];
        CfgDeadZone:    cfg_dead_q   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // sequencer, loop state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      filt_q      <= '0;
      integ_q     <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_BIAS;
          end
        end
        S_BIAS: state_q <= S_MUL;
        S_MUL:  state_q <= S_ABS;
        S_ABS: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == CntW'(DivBits - 1)) begin
            state_q <= S_POST;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_POST: begin
          filt_q  <= filt_new;
          state_q <= S_INT;
        end
        S_INT: begin
          integ_q <= 24'(integ_d);
          state_q <= S_VMUL;
        end
        S_VMUL: state_q <= S_VSUM;
        S_VSUM: state_q <= S_FIN;
        S_FIN: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    case (state_q)
      S_BIAS: begin
        bias_q <= 18'(in_q.tilt_angle) - 18'(cfg_offset_q) - 18'(cfg_tilt_q);
        err_q  <= $signed(11'({3'b0, in_q.count_left}) + 11'({3'b0, in_q.count_right})
                - 11'({3'b0, cfg_tl_q}) - 11'({3'b0, cfg_tr_q}));
      end
      S_MUL: begin
        pa_q   <= 27'(27'(bias_q) * 27'sd375);
        pb_q   <= 23'(23'(in_q.gyro_rate) * 23'sd96);
        fnum_q <= fnum_d;
      end
      S_ABS: begin
        drv_neg_q  <= num[26];
        drv_sh_q   <= num_mag;
        filt_neg_q <= fnum_q[22];
        filt_sh_q  <= {4'b0, fnum_mag};
        drv_rem_q  <= '0;
        filt_rem_q <= '0;
      end
      S_DIV: begin
        drv_sh_q   <= {drv_sh_q[DivBits-2:0], drv_ge};
        drv_rem_q  <= drv_rem_d;
        filt_sh_q  <= {filt_sh_q[DivBits-2:0], filt_ge};
        filt_rem_q <= filt_rem_d;
      end
      S_VMUL: vprod_q <= 28'(28'(filt_q) * 28'sd200);
      S_VSUM: vnum_q  <= 29'(vprod_q) + 29'(integ_q);
      // quotient and limits hold until here, so the whole result loads at once
      S_FIN: begin
        if (out_load) begin
          out_q.balance_drive  <= 15'(drive_c);
          out_q.duty           <= (duty_sum > 15'(DutyMax)) ? 14'(DutyMax) : duty_sum[13:0];
          out_q.forward        <= !drive_c[18] && (drive_c != '0);
          out_q.velocity_drive <= vel;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bvml_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvml_checker
// Port-level checks of the balance and velocity motor loop over time.
// ----------------------------------------------------------------------------
module bvml_checker
  import bvml_pkg::*;
(
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_valid_i,
  input wire            in_stall_o,
  input wire            out_valid_o,
  input wire            out_stall_i,
  input wire out_item_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one request at a time: busy right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request taken while busy");

  // no result can appear the cycle after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result without work");

  // direction bit matches the sign of the drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.forward ==
      (!out_data_o.balance_drive[14] && (out_data_o.balance_drive != '0))))
    else $error("forward disagrees with drive");

endmodule

bind balance_velocity_motor_loop_top bvml_checker u_bvml_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
